@@ rtl/rrts_pkg.sv @@
// Shared types and constants for the round-robin task scheduler.
// No dependencies; used by rrts_cell and round_robin_task_scheduler_core.
`default_nettype none

package rrts_pkg;

   // Request mode codes
   localparam logic [1:0] MODE_TICK       = 2'd0;
   localparam logic [1:0] MODE_BLOCK      = 2'd1;
   localparam logic [1:0] MODE_RESCHEDULE = 2'd2;

   // Field widths fixed by the interface
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned TICK_W  = 32;
   localparam int unsigned CFG_W   = 4;
   localparam int unsigned TASK_W  = 3;

   // Slot count limits and reset value of the slot count register
   localparam int unsigned MIN_SLOTS = 2;
   localparam int unsigned CFG_RESET = 5;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SEARCH = 2'b10
   } state_type;

   // Per-request command broadcast to every cell
   typedef struct packed {
      logic do_tick;
      logic do_block;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/rrts_cell.sv @@
// One user task slot: blocked flag, wake tick and one link of the search chain.
// Depends on rrts_pkg for the command struct and tick width.
`default_nettype none

module rrts_cell #(
   parameter int unsigned SLOT_W     = 3,
   parameter int unsigned CNT_W      = 4,
   parameter int unsigned CELL_INDEX = 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rrts_pkg::cmd_type           cmd,
   input  wire logic [SLOT_W-1:0]           run_slot,
   input  wire logic [CNT_W-1:0]            active_slots,
   input  wire logic [rrts_pkg::TICK_W-1:0] tick_next,
   input  wire logic [rrts_pkg::TICK_W-1:0] wake_value,
   input  wire logic                        hi_seen_prev,
   input  wire logic [SLOT_W-1:0]           hi_idx_prev,
   input  wire logic                        lo_seen_prev,
   input  wire logic [SLOT_W-1:0]           lo_idx_prev,
   output logic                             hi_seen_next,
   output logic [SLOT_W-1:0]                hi_idx_next,
   output logic                             lo_seen_next,
   output logic [SLOT_W-1:0]                lo_idx_next,
   output logic                             blocked
);

   localparam logic [SLOT_W-1:0] IDX     = SLOT_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0]  IDX_CNT = CNT_W'(CELL_INDEX);

   logic                        blocked_ff;
   logic                        blocked_in;
   logic [rrts_pkg::TICK_W-1:0] wake_ff;
   logic [rrts_pkg::TICK_W-1:0] wake_in;
   logic                        is_running;
   logic                        eligible;
   logic                        hi_req;
   logic                        lo_req;

   assign is_running = (run_slot == IDX);

   // Block on request, release when the new tick reaches the wake tick
   always_comb begin
      blocked_in = blocked_ff;
      wake_in    = wake_ff;
      if (cmd.do_block && is_running) begin
         blocked_in = 1'b1;
         wake_in    = wake_value;
      end else if (cmd.do_tick && blocked_ff && (wake_ff == tick_next)) begin
         blocked_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= 1'b0;
      end else begin
         blocked_ff <= blocked_in;
      end
   end

   always_ff @(posedge clock) begin
      wake_ff <= wake_in;
   end

   // Search link: upper pass takes slots after the running one, lower pass the rest
   assign eligible = !blocked_ff && (IDX_CNT < active_slots);
   assign hi_req   = eligible && (IDX > run_slot);
   assign lo_req   = eligible && (IDX <= run_slot);

   assign hi_seen_next = hi_seen_prev || hi_req;
   assign hi_idx_next  = (hi_req && !hi_seen_prev) ? IDX : hi_idx_prev;
   assign lo_seen_next = lo_seen_prev || lo_req;
   assign lo_idx_next  = (lo_req && !lo_seen_prev) ? IDX : lo_idx_prev;

   assign blocked = blocked_ff;

endmodule

`default_nettype wire

@@ rtl/round_robin_task_scheduler_core.sv @@
// Round-robin task scheduler with an always-ready idle task in slot 0.
//
// Request channel (req_valid, req_stall, req_mode, req_delay_ticks): a request
// is taken at a clock edge with req_valid high and req_stall low. Mode tick
// advances the tick counter and wakes blocked tasks whose wake tick matches;
// mode block parks the running user task until count plus delay; any other
// mode only reschedules.
// Response channel (rsp_valid, rsp_stall, rsp_next_task, rsp_tick_now): one
// response per request, held in an output register until taken.
// Configuration (csr_valid, csr_ready, csr_tasks_in_use): always ready; write
// only while no request is in flight. Values are clamped to 2..TASK_SLOTS.
//
// Timing: the cycle a request is taken, every cell applies the mode. The next
// cycle the ready search ripples along the chain of cells and loads the
// response register. No new request is taken until the search has loaded
// the response; req_stall is high while the search is pending. If a
// finished response is still stalled, the search waits and req_stall stays
// high until the register frees.
// Reset: tick counter 0, idle task running, all tasks ready, slot count 5.
// Depends on rrts_pkg and rrts_cell.
`default_nettype none

module round_robin_task_scheduler_core #(
   parameter int unsigned TASK_SLOTS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [rrts_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [rrts_pkg::TICK_W-1:0]   req_delay_ticks,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [rrts_pkg::TASK_W-1:0]        rsp_next_task,
   output logic [rrts_pkg::TICK_W-1:0]        rsp_tick_now,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rrts_pkg::CFG_W-1:0]    csr_tasks_in_use
);

   localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
   localparam int unsigned CNT_W  = $clog2(TASK_SLOTS + 1);
   localparam int unsigned WIDE_W = (CNT_W > rrts_pkg::CFG_W) ? CNT_W : rrts_pkg::CFG_W;
   localparam int unsigned RESET_SLOTS =
      (rrts_pkg::CFG_RESET > TASK_SLOTS) ? TASK_SLOTS : rrts_pkg::CFG_RESET;

   rrts_pkg::state_type          state_ff;
   rrts_pkg::state_type          state_in;
   logic [rrts_pkg::TICK_W-1:0]  tick_ff;
   logic [rrts_pkg::TICK_W-1:0]  tick_in;
   logic [rrts_pkg::TICK_W-1:0]  tick_next;
   logic [rrts_pkg::TICK_W-1:0]  wake_value;
   logic [SLOT_W-1:0]            run_ff;
   logic [SLOT_W-1:0]            run_in;
   logic [CNT_W-1:0]             slots_ff;
   logic [CNT_W-1:0]             slots_in;
   logic [WIDE_W-1:0]            cfg_wide;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [rrts_pkg::TASK_W-1:0]  rsp_task_ff;
   logic [rrts_pkg::TASK_W-1:0]  rsp_task_in;
   logic [rrts_pkg::TICK_W-1:0]  rsp_tick_ff;
   logic [rrts_pkg::TICK_W-1:0]  rsp_tick_in;
   logic                         accept;
   logic                         load;
   rrts_pkg::cmd_type            cmd;
   logic [SLOT_W-1:0]            chosen;

   // Search chain links: entry g-1 feeds cell g, entry g is its output
   logic                         hi_seen [TASK_SLOTS];
   logic [SLOT_W-1:0]            hi_idx  [TASK_SLOTS];
   logic                         lo_seen [TASK_SLOTS];
   logic [SLOT_W-1:0]            lo_idx  [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]        blocked_vec;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != rrts_pkg::ST_IDLE);
   assign load      = (state_ff == rrts_pkg::ST_SEARCH) && (!rsp_valid_ff || !rsp_stall);

   // Decode the request mode into the cell command
   always_comb begin
      cmd = '0;
      case (req_mode)
         rrts_pkg::MODE_TICK:  cmd.do_tick  = accept;
         rrts_pkg::MODE_BLOCK: cmd.do_block = accept;
         default:              cmd        = '0;
      endcase
   end

   assign tick_next  = tick_ff + rrts_pkg::TICK_W'(1);
   assign wake_value = tick_ff + req_delay_ticks;
   assign tick_in    = cmd.do_tick ? tick_next : tick_ff;

   // Row of user task cells
   assign hi_seen[0]     = 1'b0;
   assign hi_idx[0]      = '0;
   assign lo_seen[0]     = 1'b0;
   assign lo_idx[0]      = '0;
   assign blocked_vec[0] = 1'b0;

   for (genvar g = 1; g < TASK_SLOTS; g++) begin : g_cell
      rrts_cell #(
         .SLOT_W     (SLOT_W),
         .CNT_W      (CNT_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .run_slot     (run_ff),
         .active_slots (slots_ff),
         .tick_next    (tick_next),
         .wake_value   (wake_value),
         .hi_seen_prev (hi_seen[g-1]),
         .hi_idx_prev  (hi_idx[g-1]),
         .lo_seen_prev (lo_seen[g-1]),
         .lo_idx_prev  (lo_idx[g-1]),
         .hi_seen_next (hi_seen[g]),
         .hi_idx_next  (hi_idx[g]),
         .lo_seen_next (lo_seen[g]),
         .lo_idx_next  (lo_idx[g]),
         .blocked      (blocked_vec[g])
      );
   end

   // Pick the upper-pass winner first, then wrap, else fall back to idle
   always_comb begin
      if (hi_seen[TASK_SLOTS-1]) begin
         chosen = hi_idx[TASK_SLOTS-1];
      end else if (lo_seen[TASK_SLOTS-1]) begin
         chosen = lo_idx[TASK_SLOTS-1];
      end else begin
         chosen = '0;
      end
   end

   // Sequence: take a request, then search and load the response
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrts_pkg::ST_IDLE:   if (accept) state_in = rrts_pkg::ST_SEARCH;
         rrts_pkg::ST_SEARCH: if (load)   state_in = rrts_pkg::ST_IDLE;
         default:             state_in = rrts_pkg::ST_IDLE;
      endcase
   end

   assign run_in = load ? chosen : run_ff;

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_task_in  = rsp_task_ff;
      rsp_tick_in  = rsp_tick_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_task_in  = rrts_pkg::TASK_W'(chosen);
         rsp_tick_in  = tick_ff;
      end
   end

   // Clamp the slot count on a write
   assign cfg_wide = WIDE_W'(csr_tasks_in_use);
   always_comb begin
      slots_in = slots_ff;
      if (csr_valid && csr_ready) begin
         if (cfg_wide < WIDE_W'(rrts_pkg::MIN_SLOTS)) begin
            slots_in = CNT_W'(rrts_pkg::MIN_SLOTS);
         end else if (cfg_wide > WIDE_W'(TASK_SLOTS)) begin
            slots_in = CNT_W'(TASK_SLOTS);
         end else begin
            slots_in = CNT_W'(cfg_wide);
         end
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrts_pkg::ST_IDLE;
         tick_ff      <= '0;
         run_ff       <= '0;
         slots_ff     <= CNT_W'(RESET_SLOTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         run_ff       <= run_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_task_ff <= rsp_task_in;
      rsp_tick_ff <= rsp_tick_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_task = rsp_task_ff;
   assign rsp_tick_now  = rsp_tick_ff;

   // A newly chosen user task is never a blocked one
   a_chosen_ready: assert property (@(posedge clock) disable iff (reset)
      load |=> (run_ff == '0) || !blocked_vec[run_ff])
      else $error("scheduled a blocked task");

   // A tick request advances the counter by one
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == rrts_pkg::MODE_TICK) |=> tick_ff == $past(tick_ff) + 32'd1)
      else $error("tick counter did not advance");

   // Other requests leave the counter alone
   a_tick_hold: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode != rrts_pkg::MODE_TICK) |=> $stable(tick_ff))
      else $error("tick counter moved without a tick");

   // The response carries the counter as it stood after the request
   a_rsp_tick: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff && (rsp_tick_ff == tick_ff))
      else $error("response tick mismatch");

   // A chosen slot lies inside the slots in use
   a_chosen_range: assert property (@(posedge clock) disable iff (reset)
      load |-> (CNT_W'(chosen) < slots_ff))
      else $error("chosen slot outside slots in use");

endmodule

`default_nettype wire

@@ verif/rrts_sched_checker.sv @@
// Checker for the round-robin task scheduler: watches the request, response and
// slot-count channels, predicts each scheduling decision and compares it.
// Depends on rrts_pkg for field widths, mode codes and the slot count reset value.
module rrts_sched_checker #(
   parameter int unsigned SLOTS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [rrts_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [rrts_pkg::TICK_W-1:0]   req_delay_ticks,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [rrts_pkg::TASK_W-1:0]   rsp_next_task,
   input  wire logic [rrts_pkg::TICK_W-1:0]   rsp_tick_now,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [rrts_pkg::CFG_W-1:0]    csr_tasks_in_use,
   output int unsigned                        fail_count,
   output int unsigned                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [rrts_pkg::TASK_W-1:0] next_task;
      logic [rrts_pkg::TICK_W-1:0] tick_now;
   } decision_type;

   // Predicted scheduler state
   logic [rrts_pkg::TICK_W-1:0] tick_count;
   int unsigned                 current_slot;
   logic                        slot_blocked [SLOTS];
   logic [rrts_pkg::TICK_W-1:0] slot_wake_at [SLOTS];
   logic [rrts_pkg::CFG_W-1:0]  slot_setting;

   decision_type pending_decisions [$];
   int unsigned  errors = 0;

   // Apply one request to the predicted state and return the decision it yields
   function automatic decision_type schedule_request(logic [rrts_pkg::MODE_W-1:0] mode,
                                                     logic [rrts_pkg::TICK_W-1:0] delay);
      int unsigned  span;
      int unsigned  cand;
      decision_type res;
      span = slot_setting;
      if (span < rrts_pkg::MIN_SLOTS) span = rrts_pkg::MIN_SLOTS;
      if (span > SLOTS) span = SLOTS;
      if (mode == rrts_pkg::MODE_TICK) begin
         tick_count = tick_count + 1'b1;
         // wake every user slot due now, in use or not
         for (int s = 1; s < SLOTS; s++) begin
            if (slot_blocked[s] && slot_wake_at[s] == tick_count) slot_blocked[s] = 1'b0;
         end
      end else if (mode == rrts_pkg::MODE_BLOCK && current_slot != 0) begin
         slot_blocked[current_slot] = 1'b1;
         slot_wake_at[current_slot] = tick_count + delay;
      end
      // search from the slot after the running one, running slot last, idle fallback
      cand = current_slot;
      current_slot = 0;
      for (int i = 0; i < span; i++) begin
         cand = cand + 1;
         if (cand >= span) cand = 0;
         if (cand != 0 && !slot_blocked[cand]) begin
            current_slot = cand;
            break;
         end
      end
      res.next_task = rrts_pkg::TASK_W'(current_slot);
      res.tick_now  = tick_count;
      return res;
   endfunction

   task automatic log_failure(string what);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin : monitor
      decision_type want;
      if (reset) begin
         tick_count   = '0;
         current_slot = 0;
         slot_setting = rrts_pkg::CFG_W'(rrts_pkg::CFG_RESET);
         for (int s = 0; s < SLOTS; s++) begin
            slot_blocked[s] = 1'b0;
            slot_wake_at[s] = '0;
         end
         pending_decisions.delete();
      end else begin
         if (csr_valid && csr_ready) slot_setting = csr_tasks_in_use;
         // retire the oldest decision before queueing a new one
         if (rsp_valid && !rsp_stall) begin
            if (pending_decisions.size() == 0) begin
               log_failure($sformatf("unexpected response: next_task %0d tick_now %0d",
                                     rsp_next_task, rsp_tick_now));
            end else begin
               want = pending_decisions.pop_front();
               if (rsp_next_task !== want.next_task)
                  log_failure($sformatf("next_task mismatch: expected %0d, got %0d",
                                        want.next_task, rsp_next_task));
               if (rsp_tick_now !== want.tick_now)
                  log_failure($sformatf("tick_now mismatch: expected %0d, got %0d",
                                        want.tick_now, rsp_tick_now));
            end
         end
         if (req_valid && !req_stall)
            pending_decisions.push_back(schedule_request(req_mode, req_delay_ticks));
      end
      outstanding <= pending_decisions.size();
      fail_count  <= errors;
   end

endmodule

@@ verif/tb.sv @@
// Top of the scheduler testbench: clock, reset, request and slot-count stimulus,
// response back-pressure, a watchdog and the verdict.
// Depends on rrts_pkg, round_robin_task_scheduler_core and rrts_sched_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOTS         = 8;
   localparam logic [1:0]  MODE_SPARE    = 2'd3;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned PHASE_ITEMS   = 40;
   localparam int unsigned STALL_HOLD    = 60;
   localparam int unsigned HOLD_AFTER    = 150;
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned SETTLE        = 4;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic [rrts_pkg::MODE_W-1:0]   req_mode         = rrts_pkg::MODE_TICK;
   logic [rrts_pkg::TICK_W-1:0]   req_delay_ticks  = '0;
   logic                          rsp_stall        = 1'b0;
   logic                          csr_valid        = 1'b0;
   logic [rrts_pkg::CFG_W-1:0]    csr_tasks_in_use = rrts_pkg::CFG_W'(rrts_pkg::CFG_RESET);
   wire logic                     req_stall;
   wire logic                     rsp_valid;
   wire logic [rrts_pkg::TASK_W-1:0] rsp_next_task;
   wire logic [rrts_pkg::TICK_W-1:0] rsp_tick_now;
   wire logic                     csr_ready;
   int unsigned                   mismatches;
   int unsigned                   awaited;
   logic                          sender_calm = 1'b0;

   round_robin_task_scheduler_core #(.TASK_SLOTS(SLOTS)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_delay_ticks  (req_delay_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_task    (rsp_next_task),
      .rsp_tick_now     (rsp_tick_now),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_tasks_in_use (csr_tasks_in_use)
   );

   rrts_sched_checker #(.SLOTS(SLOTS)) sched_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_delay_ticks  (req_delay_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_task    (rsp_next_task),
      .rsp_tick_now     (rsp_tick_now),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_tasks_in_use (csr_tasks_in_use),
      .fail_count       (mismatches),
      .outstanding      (awaited)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // Offer one request and hold it until taken
   task automatic issue(input logic [rrts_pkg::MODE_W-1:0] mode,
                        input logic [rrts_pkg::TICK_W-1:0] delay);
      int unsigned gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_delay_ticks <= delay;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait for every outstanding decision to come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_slots(input logic [rrts_pkg::CFG_W-1:0] value);
      csr_valid        <= 1'b1;
      csr_tasks_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Request stimulus and verdict
   initial begin : stimulus
      logic [rrts_pkg::CFG_W-1:0]  slot_plan [RANDOM_PHASES];
      logic [rrts_pkg::MODE_W-1:0] mode;
      logic [rrts_pkg::TICK_W-1:0] delay;
      int unsigned                 r;
      slot_plan = '{4'd15, 4'd0, 4'd8, 4'd1, 4'd3, 4'd9, 4'd2, 4'd6, 4'd7, 4'd4};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset slot count: both reschedule codes, blocking, waking, all blocked
      issue(rrts_pkg::MODE_RESCHEDULE, 32'd0);
      issue(MODE_SPARE, 32'h5555_5555);
      issue(rrts_pkg::MODE_BLOCK, 32'd3);
      issue(rrts_pkg::MODE_TICK, 32'hFFFF_FFFF);
      issue(rrts_pkg::MODE_TICK, 32'h0000_0000);
      issue(rrts_pkg::MODE_TICK, 32'hAAAA_AAAA);
      issue(rrts_pkg::MODE_BLOCK, 32'd1);
      issue(rrts_pkg::MODE_BLOCK, 32'd2);
      issue(rrts_pkg::MODE_BLOCK, 32'd1);
      issue(rrts_pkg::MODE_BLOCK, 32'd5);
      // block while idle runs: must be dropped
      issue(rrts_pkg::MODE_BLOCK, 32'hFFFF_FFFF);
      issue(rrts_pkg::MODE_TICK, 32'd0);
      issue(rrts_pkg::MODE_RESCHEDULE, 32'hFFFF_FFFF);
      drain();

      // all slots: park the top two slots with a zero delay and an all-ones delay
      write_slots(4'd8);
      issue(rrts_pkg::MODE_RESCHEDULE, 32'd0);
      issue(rrts_pkg::MODE_RESCHEDULE, 32'd0);
      issue(rrts_pkg::MODE_BLOCK, 32'd0);
      issue(rrts_pkg::MODE_BLOCK, 32'hFFFF_FFFF);
      issue(rrts_pkg::MODE_TICK, 32'd0);
      issue(rrts_pkg::MODE_RESCHEDULE, 32'd0);
      drain();

      // fewest slots with the running slot left outside them
      write_slots(4'd2);
      issue(rrts_pkg::MODE_RESCHEDULE, 32'd0);
      issue(rrts_pkg::MODE_TICK, 32'd0);
      issue(rrts_pkg::MODE_TICK, 32'd0);
      issue(rrts_pkg::MODE_TICK, 32'd0);
      drain();

      // random phases, one slot count each
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_slots(slot_plan[p]);
         sender_calm = (p % 3 == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40) mode = rrts_pkg::MODE_TICK;
            else if (r < 70) mode = rrts_pkg::MODE_BLOCK;
            else if (r < 95) mode = rrts_pkg::MODE_RESCHEDULE;
            else mode = MODE_SPARE;
            // keep block delays reachable; other modes ignore the field
            if (mode == rrts_pkg::MODE_BLOCK)
               delay = ($urandom_range(0, 99) < 3) ? $urandom_range(11, 60)
                                                     : $urandom_range(1, 10);
            else
               delay = $urandom();
            issue(mode, delay);
         end
         drain();
      end

      if (mismatches == 0 && awaited == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Response back-pressure: random gaps, calm stretches and one long hold
   initial begin : response_side
      int unsigned seen;
      int unsigned hold_left;
      int unsigned gap_left;
      int unsigned calm_left;
      bit          held_once;
      seen      = 0;
      hold_left = 0;
      gap_left  = 0;
      calm_left = 0;
      held_once = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) seen++;
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!held_once && seen >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = STALL_HOLD - 1;
            rsp_stall <= 1'b1;
         end else if (calm_left != 0) begin
            rsp_stall <= 1'b0;
            calm_left--;
         end else if (gap_left != 0) begin
            rsp_stall <= 1'b1;
            gap_left--;
         end else if ($urandom_range(0, 99) < 4) begin
            calm_left = $urandom_range(30, 80);
            rsp_stall <= 1'b0;
         end else begin
            gap_left = pick_gap();
            if (gap_left != 0) begin
               rsp_stall <= 1'b1;
               gap_left--;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Abort when no channel has moved a request for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule
